// ===== hw/rtl/efr_pkg.sv =====
// Package for the escaped frame receiver: framing byte codes, status codes
// and the result item type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

   localparam int unsigned RAW_COUNT_W = 4;
   localparam int unsigned DEC_COUNT_W = 4;

   localparam logic [7:0] BYTE_START = 8'h0c;
   localparam logic [7:0] BYTE_END   = 8'hc0;
   localparam logic [7:0] BYTE_ESC   = 8'hdb;
   localparam logic [7:0] ESC_DB     = 8'hdd;
   localparam logic [7:0] ESC_END    = 8'hdc;
   localparam logic [7:0] ESC_START  = 8'hde;

   localparam logic [DEC_COUNT_W-1:0] DEC_COUNT_MAX = {DEC_COUNT_W{1'b1}};

   localparam logic [7:0] ADDR_RESET = 8'hff;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_ESCAPE = 3'd1,
      ST_TOO_SHORT  = 3'd2,
      ST_CHECKSUM   = 3'd3,
      ST_WRONG_ADDR = 3'd4
   } frame_status_type;

   typedef struct packed {
      frame_status_type status;
      logic [7:0]       command;
      logic             overflowed;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/efr_frame_engine.sv =====
// Frame state and per-byte decode for the escaped frame receiver.
// Depends on efr_pkg for byte codes, status codes and the result type.
`timescale 1ns / 1ps
`default_nettype none

module efr_frame_engine #(
   parameter int unsigned MAX_RAW = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [7:0]        device_address,
   output logic                   emit,
   output efr_pkg::result_type    result
);

   localparam logic [efr_pkg::RAW_COUNT_W-1:0] RAW_LIMIT = efr_pkg::RAW_COUNT_W'(MAX_RAW);

   logic                              in_frame_ff, in_frame_in;
   logic                              esc_pend_ff, esc_pend_in;
   logic                              esc_err_ff, esc_err_in;
   logic [efr_pkg::RAW_COUNT_W-1:0]   raw_count_ff, raw_count_in;
   logic [efr_pkg::DEC_COUNT_W-1:0]   dec_count_ff, dec_count_in;
   logic [7:0]                        sum_ff, sum_in;
   logic [7:0]                        last_ff, last_in;
   logic [7:0]                        first_ff, first_in;
   logic [7:0]                        second_ff, second_in;

   // state after decoding the current byte
   logic                              d_pend, d_err;
   logic [efr_pkg::DEC_COUNT_W-1:0]   d_count;
   logic [7:0]                        d_sum, d_last, d_first, d_second;
   logic                              take;
   logic [7:0]                        take_byte;
   logic [efr_pkg::RAW_COUNT_W-1:0]   raw_next;

   // values checked at frame close
   logic                              c_err;
   logic [efr_pkg::DEC_COUNT_W-1:0]   c_count;
   logic [7:0]                        c_sum, c_last, c_first, c_second;
   logic                              c_over;

   assign raw_next = raw_count_ff + 1'b1;

   always_comb begin
      d_pend    = esc_pend_ff;
      d_err     = esc_err_ff;
      take      = 1'b0;
      take_byte = rx_byte;
      if (!esc_err_ff) begin
         if (esc_pend_ff) begin
            d_pend = 1'b0;
            case (rx_byte)
               efr_pkg::ESC_DB: begin
                  take      = 1'b1;
                  take_byte = efr_pkg::BYTE_ESC;
               end
               efr_pkg::ESC_END: begin
                  take      = 1'b1;
                  take_byte = efr_pkg::BYTE_END;
               end
               efr_pkg::ESC_START: begin
                  take      = 1'b1;
                  take_byte = efr_pkg::BYTE_START;
               end
               default: begin
                  d_err = 1'b1;
               end
            endcase
         end else if (rx_byte == efr_pkg::BYTE_ESC) begin
            d_pend = 1'b1;
         end else begin
            take = 1'b1;
         end
      end

      d_count  = dec_count_ff;
      d_sum    = sum_ff;
      d_last   = last_ff;
      d_first  = first_ff;
      d_second = second_ff;
      if (take) begin
         if (dec_count_ff == '0) begin
            d_first = take_byte;
         end
         if (dec_count_ff == efr_pkg::DEC_COUNT_W'(1)) begin
            d_second = take_byte;
         end
         if (dec_count_ff != efr_pkg::DEC_COUNT_MAX) begin
            d_count = dec_count_ff + 1'b1;
         end
         d_sum  = sum_ff + take_byte;
         d_last = take_byte;
      end
   end

   always_comb begin
      in_frame_in  = in_frame_ff;
      esc_pend_in  = esc_pend_ff;
      esc_err_in   = esc_err_ff;
      raw_count_in = raw_count_ff;
      dec_count_in = dec_count_ff;
      sum_in       = sum_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      emit         = 1'b0;
      c_err        = esc_err_ff;
      c_count      = dec_count_ff;
      c_sum        = sum_ff;
      c_last       = last_ff;
      c_first      = first_ff;
      c_second     = second_ff;
      c_over       = 1'b0;

      if (rx_byte == efr_pkg::BYTE_START) begin
         in_frame_in  = 1'b1;
         esc_pend_in  = 1'b0;
         esc_err_in   = 1'b0;
         raw_count_in = '0;
         dec_count_in = '0;
         sum_in       = '0;
         last_in      = '0;
         first_in     = '0;
         second_in    = '0;
      end else if (rx_byte == efr_pkg::BYTE_END) begin
         if (in_frame_ff) begin
            emit        = 1'b1;
            in_frame_in = 1'b0;
         end
      end else if (in_frame_ff) begin
         raw_count_in = raw_next;
         esc_pend_in  = d_pend;
         esc_err_in   = d_err;
         dec_count_in = d_count;
         sum_in       = d_sum;
         last_in      = d_last;
         first_in     = d_first;
         second_in    = d_second;
         c_err        = d_err;
         c_count      = d_count;
         c_sum        = d_sum;
         c_last       = d_last;
         c_first      = d_first;
         c_second     = d_second;
         if (raw_next >= RAW_LIMIT) begin
            emit        = 1'b1;
            c_over      = 1'b1;
            in_frame_in = 1'b0;
         end
      end
   end

   always_comb begin
      result.command    = '0;
      result.overflowed = c_over;
      if (c_err) begin
         result.status = efr_pkg::ST_BAD_ESCAPE;
      end else if (c_count < efr_pkg::DEC_COUNT_W'(2)) begin
         result.status = efr_pkg::ST_TOO_SHORT;
      end else if ((c_sum - c_last) != c_last) begin
         result.status = efr_pkg::ST_CHECKSUM;
      end else if (c_first != device_address) begin
         result.status = efr_pkg::ST_WRONG_ADDR;
      end else begin
         result.status  = efr_pkg::ST_OK;
         result.command = c_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         esc_pend_ff  <= 1'b0;
         esc_err_ff   <= 1'b0;
         raw_count_ff <= '0;
         dec_count_ff <= '0;
         sum_ff       <= '0;
         last_ff      <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
      end else if (advance) begin
         in_frame_ff  <= in_frame_in;
         esc_pend_ff  <= esc_pend_in;
         esc_err_ff   <= esc_err_in;
         raw_count_ff <= raw_count_in;
         dec_count_ff <= dec_count_in;
         sum_ff       <= sum_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/escaped_frame_receiver_top.sv =====
// A frame-closing item is decoded from the input register in the cycle after it is
// accepted; its result is written to the result register when that item advances.
// Throughput: one item per cycle; the input register stalls only when a
// closing item meets a full result register that is not being drained.
// Reset (synchronous, active high) clears frame state; device_address = 0xff.
// Top level: input register, efr_frame_engine, result register, csr register.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver_top #(
   parameter int unsigned MAX_RAW = 10
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_frame_status,
   output logic [7:0]      rsp_command,
   output logic            rsp_overflowed,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   efr_pkg::result_type rsp_ff;
   logic [7:0]          addr_ff;
   logic                advance;
   logic                emit;
   efr_pkg::result_type result;

   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   efr_frame_engine #(
      .MAX_RAW (MAX_RAW)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .rx_byte        (in_byte_ff),
      .device_address (addr_ff),
      .emit           (emit),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= efr_pkg::ADDR_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            addr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_ff.status;
   assign rsp_command      = rsp_ff.command;
   assign rsp_overflowed   = rsp_ff.overflowed;

   // a result is never written over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(advance && emit && rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten");

   // stall only with an item held in the input register
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff)
      else $error("input stalled while empty");

   // command is zero unless the frame is ok
   a_cmd_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ff.status != efr_pkg::ST_OK) |-> (rsp_command == 8'd0))
      else $error("command set on failed frame");

   // overflow results come only with a non-framing closing byte
   a_overflow_source: assert property (@(posedge clock) disable iff (reset)
      advance && emit && result.overflowed |-> (in_byte_ff != efr_pkg::BYTE_END))
      else $error("overflow flagged on end byte");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for escaped_frame_receiver_top: byte-stuffed frames in,
// one status item per closed frame out, checked against an in-bench frame decoder.
// Depends on efr_pkg and escaped_frame_receiver_top.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned FRAME_RAW_LIMIT = 10;
   localparam int unsigned PHASE_ITEMS = 220;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_frame_status;
   logic [7:0] rsp_command;
   logic       rsp_overflowed;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   // frame decoder state
   logic       in_frame = 1'b0;
   logic       esc_pending = 1'b0;
   logic       esc_error = 1'b0;
   logic [3:0] raw_count = '0;
   logic [3:0] dec_count = '0;
   logic [7:0] byte_sum = '0;
   logic [7:0] last_byte = '0;
   logic [7:0] addr_byte = '0;
   logic [7:0] cmd_byte = '0;
   logic [7:0] own_address = efr_pkg::ADDR_RESET;

   efr_pkg::result_type expected_frames[$];
   int         frame_items = 0;
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_off_cycles = 0;

   escaped_frame_receiver_top #(
      .MAX_RAW(FRAME_RAW_LIMIT)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_command      (rsp_command),
      .rsp_overflowed   (rsp_overflowed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void take_decoded(input logic [7:0] d);
      if (dec_count == 4'd0) addr_byte = d;
      else if (dec_count == 4'd1) cmd_byte = d;
      if (dec_count != efr_pkg::DEC_COUNT_MAX) dec_count = dec_count + 4'd1;
      byte_sum = byte_sum + d;
      last_byte = d;
   endfunction

   function automatic void close_frame(input logic over);
      efr_pkg::result_type r;
      logic [7:0] before_last;
      before_last = byte_sum - last_byte;
      r.command = 8'h00;
      r.overflowed = over;
      if (esc_error) r.status = efr_pkg::ST_BAD_ESCAPE;
      else if (dec_count < 4'd2) r.status = efr_pkg::ST_TOO_SHORT;
      else if (before_last != last_byte) r.status = efr_pkg::ST_CHECKSUM;
      else if (addr_byte != own_address) r.status = efr_pkg::ST_WRONG_ADDR;
      else begin
         r.status = efr_pkg::ST_OK;
         r.command = cmd_byte;
      end
      in_frame = 1'b0;
      expected_frames.push_back(r);
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      if (b == efr_pkg::BYTE_START) begin
         esc_pending = 1'b0;
         esc_error = 1'b0;
         raw_count = '0;
         dec_count = '0;
         byte_sum = '0;
         last_byte = '0;
         addr_byte = '0;
         cmd_byte = '0;
         in_frame = 1'b1;
         frame_items++;
      end else if (in_frame) begin
         frame_items++;
         if (b == efr_pkg::BYTE_END) begin
            close_frame(1'b0);
         end else begin
            raw_count = raw_count + 4'd1;
            if (!esc_error) begin
               if (esc_pending) begin
                  esc_pending = 1'b0;
                  if (b == efr_pkg::ESC_DB) take_decoded(efr_pkg::BYTE_ESC);
                  else if (b == efr_pkg::ESC_END) take_decoded(efr_pkg::BYTE_END);
                  else if (b == efr_pkg::ESC_START) take_decoded(efr_pkg::BYTE_START);
                  else esc_error = 1'b1;
               end else if (b == efr_pkg::BYTE_ESC) begin
                  esc_pending = 1'b1;
               end else begin
                  take_decoded(b);
               end
            end
            if (raw_count >= FRAME_RAW_LIMIT) close_frame(1'b1);
         end
      end
   endfunction

   always @(posedge clock) begin
      efr_pkg::result_type want;
      if (!reset) begin
         if (req_valid && req_ready) absorb_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected item status=%0d cmd=%02h ovf=%0b",
                  rsp_frame_status, rsp_command, rsp_overflowed));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_frame_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                     rsp_frame_status, want.status));
               if (rsp_command !== want.command)
                  report_mismatch($sformatf("command %02h, want %02h",
                     rsp_command, want.command));
               if (rsp_overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed %0b, want %0b",
                     rsp_overflowed, want.overflowed));
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            while (hold_off_cycles != 0) begin
               @(posedge clock);
               hold_off_cycles--;
            end
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic offer_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic offer_bytes(input logic [7:0] seq[$]);
      foreach (seq[i]) offer_byte(seq[i]);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_device_address(input logic [7:0] addr);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      own_address = addr;
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] specials[6];
      specials = '{efr_pkg::BYTE_START, efr_pkg::BYTE_END, efr_pkg::BYTE_ESC,
                   efr_pkg::ESC_DB, efr_pkg::ESC_END, efr_pkg::ESC_START};
      if ($urandom_range(3) == 0) return specials[$urandom_range(5)];
      return 8'($urandom_range(255));
   endfunction

   task automatic send_stuffed(input logic [7:0] d);
      if (d == efr_pkg::BYTE_ESC) offer_bytes({efr_pkg::BYTE_ESC, efr_pkg::ESC_DB});
      else if (d == efr_pkg::BYTE_END) offer_bytes({efr_pkg::BYTE_ESC, efr_pkg::ESC_END});
      else if (d == efr_pkg::BYTE_START)
         offer_bytes({efr_pkg::BYTE_ESC, efr_pkg::ESC_START});
      else offer_byte(d);
   endtask

   task automatic send_random_frame(input int good_pct);
      logic [7:0] decoded[$];
      logic [7:0] total;
      logic [7:0] bad;
      int         kind;
      int         keep;
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 12)) offer_byte(pick_byte());
      end else begin
         total = 8'h00;
         decoded.push_back(($urandom_range(99) < good_pct) ? own_address : pick_byte());
         repeat ($urandom_range(1, 5)) decoded.push_back(pick_byte());
         foreach (decoded[i]) total = total + decoded[i];
         if ($urandom_range(9) == 0) total = total + 8'($urandom_range(1, 255));
         decoded.push_back(total);
         if (kind < 20) begin
            keep = $urandom_range(1);
            while (decoded.size() > keep) void'(decoded.pop_back());
         end
         offer_byte(efr_pkg::BYTE_START);
         foreach (decoded[i]) begin
            if ($urandom_range(29) == 0) begin
               do bad = 8'($urandom_range(255));
               while (bad inside {efr_pkg::ESC_DB, efr_pkg::ESC_END, efr_pkg::ESC_START,
                                  efr_pkg::BYTE_START, efr_pkg::BYTE_END});
               offer_bytes({efr_pkg::BYTE_ESC, bad});
            end
            send_stuffed(decoded[i]);
         end
         if ($urandom_range(19) == 0) offer_byte(efr_pkg::BYTE_ESC);
         if ($urandom_range(9) != 0) offer_byte(efr_pkg::BYTE_END);
      end
   endtask

   task automatic test_directed_frames();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // restart after a pending escape; all escape codes; close on raw limit
      offer_bytes({efr_pkg::BYTE_START, 8'h77, efr_pkg::BYTE_ESC, efr_pkg::BYTE_START,
                   8'hff, efr_pkg::BYTE_ESC, efr_pkg::ESC_END,
                   efr_pkg::BYTE_ESC, efr_pkg::ESC_START, efr_pkg::BYTE_ESC,
                   efr_pkg::ESC_DB, 8'h00, 8'h00, 8'ha6});
      // bad escape wins over too short
      offer_bytes({efr_pkg::BYTE_START, efr_pkg::BYTE_ESC, 8'h00, efr_pkg::BYTE_END});
      // ignored outside a frame
      offer_bytes({efr_pkg::BYTE_END, 8'h55});
      // escaped end byte still ends; lone escape dropped; too short
      offer_bytes({efr_pkg::BYTE_START, 8'h01, efr_pkg::BYTE_ESC, efr_pkg::BYTE_END});
      offer_bytes({efr_pkg::BYTE_START, 8'hff, 8'h01, 8'h55, efr_pkg::BYTE_END});
      offer_bytes({efr_pkg::BYTE_START, 8'h00, 8'h00, 8'h00, efr_pkg::BYTE_END});
      offer_bytes({efr_pkg::BYTE_START, 8'hff, 8'h05, 8'h04, efr_pkg::BYTE_END});
      wait_idle();
   endtask

   task automatic test_random_frames(input logic [7:0] addr, input int idle_pct,
                                     input int stall_pct);
      int target;
      set_device_address(addr);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = frame_items + PHASE_ITEMS;
      while (frame_items < target) send_random_frame(75);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      set_device_address(8'h5a);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 400;
      repeat (30) send_random_frame(100);
      wait_idle();
   endtask

   initial begin
      int guard;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_random_frames(8'h00, 0, 0);
      test_random_frames(8'($urandom_range(255)), 80, 0);
      test_random_frames(8'hff, 0, 80);
      test_random_frames(efr_pkg::BYTE_ESC, 11, 11);
      test_output_backpressure();
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      guard = 0;
      while (expected_frames.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (expected_frames.size() != 0)
         report_mismatch($sformatf("%0d items never arrived", expected_frames.size()));
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
